@@ rtl/core/dmxft_pkg.sv @@
// shared types and constants for the dmx512 frame transmitter
package dmxft_pkg;

    localparam int MAX_SLOTS_DEF = 512;
    localparam int BYTE_W        = 8;
    localparam int TICK_W        = 10;

    localparam logic [TICK_W-1:0] BREAK_TICKS_RST = 10'd100;
    localparam logic [TICK_W-1:0] MAB_TICKS_RST   = 10'd20;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NEXT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_NO_BYTE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_BREAK = 4'b0010,
        PH_MARK  = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    typedef enum logic {
        REG_BREAK_TICKS = 1'b0,
        REG_MAB_TICKS   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd              command;
        logic [8:0]        slot_index;
        logic [BYTE_W-1:0] slot_value;
        logic [9:0]        slot_count;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic              line_low;
        logic              data_ready;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              frame_end;
    } t_out;

endpackage

@@ rtl/core/dmxft_slot_ram.sv @@
// slot byte memory, one write port and one registered read port
module dmxft_slot_ram #(
    parameter int DEPTH = dmxft_pkg::MAX_SLOTS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [dmxft_pkg::BYTE_W-1:0]                i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [dmxft_pkg::BYTE_W-1:0]                o_rdata
);

    logic [dmxft_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [dmxft_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dmx512_frame_transmitter_core.sv @@
// dmx512 frame sequencer top level: slot memory, break/mab timing, byte fetch
// each result passes through the result stage and the output register
// throughput: one transaction per cycle unless the output stalls or memory clears
// reset: synchronous; break_ticks 100, mab_ticks 20, line idle
// after reset a clearing pass zeroes every slot memory address,
// input stalled until it ends
module dmx512_frame_transmitter_core #(
    parameter int MAX_SLOTS = dmxft_pkg::MAX_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dmxft_pkg::t_in       i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dmxft_pkg::t_out      o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FRAME_LEN = MAX_SLOTS + 1;
    localparam int IDX_W     = $clog2(MAX_SLOTS + 2);
    localparam int TW        = dmxft_pkg::TICK_W;

    logic [TW-1:0]         r_break_ticks;
    logic [TW-1:0]         r_mab_ticks;
    dmxft_pkg::t_phase     r_phase;
    dmxft_pkg::t_phase     n_phase;
    logic [TW-1:0]         r_timer;
    logic [TW-1:0]         n_timer;
    logic [IDX_W-1:0]      r_bidx;
    logic [IDX_W-1:0]      n_bidx;
    logic                  r_clr;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_s1_vld;
    dmxft_pkg::t_out       r_s1_res;
    logic                  r_s1_mem;
    logic                  r_out_vld;
    dmxft_pkg::t_out       r_out;

    dmxft_pkg::t_out       res;
    logic                  wr_ok;
    logic                  rd_mem;
    logic                  acc;
    logic                  s1_adv;
    logic                  cfg_wr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [dmxft_pkg::BYTE_W-1:0] mem_wdata;
    logic [dmxft_pkg::BYTE_W-1:0] mem_rdata;
    dmxft_pkg::t_out       s1_out;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_ticks <= dmxft_pkg::BREAK_TICKS_RST;
            r_mab_ticks   <= dmxft_pkg::MAB_TICKS_RST;
        end else if (cfg_wr) begin
            if (dmxft_pkg::t_reg_idx'(paddr[2]) == dmxft_pkg::REG_BREAK_TICKS) begin
                r_break_ticks <= pwdata[TW-1:0];
            end else begin
                r_mab_ticks <= pwdata[TW-1:0];
            end
        end
    end

    always_comb begin
        if (dmxft_pkg::t_reg_idx'(paddr[2]) == dmxft_pkg::REG_BREAK_TICKS) begin
            prdata = {{(32-TW){1'b0}}, r_break_ticks};
        end else begin
            prdata = {{(32-TW){1'b0}}, r_mab_ticks};
        end
    end

    // handshake
    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_clr || (r_s1_vld && !s1_adv);
    assign acc        = i_in_valid && !o_in_stall;

    // command decode and next state
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_bidx  = r_bidx;
        wr_ok   = 1'b0;
        rd_mem  = 1'b0;
        res     = '0;
        res.status = dmxft_pkg::ST_OK;
        case (i_in_data.command)
            dmxft_pkg::CMD_WRITE: begin
                if (r_phase != dmxft_pkg::PH_IDLE) begin
                    res.status = dmxft_pkg::ST_BUSY;
                end else if (32'(i_in_data.slot_index) >= 32'(MAX_SLOTS)) begin
                    res.status = dmxft_pkg::ST_TOO_MANY;
                end else begin
                    wr_ok = 1'b1;
                end
            end
            dmxft_pkg::CMD_START: begin
                if (r_phase != dmxft_pkg::PH_IDLE) begin
                    res.status = dmxft_pkg::ST_BUSY;
                end else if (32'(i_in_data.slot_count) > 32'(MAX_SLOTS)) begin
                    res.status = dmxft_pkg::ST_TOO_MANY;
                end else begin
                    n_phase = dmxft_pkg::PH_BREAK;
                    n_timer = r_break_ticks;
                end
            end
            dmxft_pkg::CMD_TICK: begin
                if (r_phase == dmxft_pkg::PH_BREAK) begin
                    if (r_timer <= TW'(1)) begin
                        n_phase = dmxft_pkg::PH_MARK;
                        n_timer = r_mab_ticks;
                    end else begin
                        n_timer = r_timer - TW'(1);
                    end
                end else if (r_phase == dmxft_pkg::PH_MARK) begin
                    if (r_timer <= TW'(1)) begin
                        n_phase = dmxft_pkg::PH_DATA;
                        n_timer = '0;
                        n_bidx  = '0;
                        res.data_ready = 1'b1;
                    end else begin
                        n_timer = r_timer - TW'(1);
                    end
                end
            end
            dmxft_pkg::CMD_NEXT: begin
                if (r_phase != dmxft_pkg::PH_DATA) begin
                    res.status = dmxft_pkg::ST_NO_BYTE;
                end else if (32'(r_bidx) < 32'(FRAME_LEN)) begin
                    res.tx_valid = 1'b1;
                    rd_mem = (r_bidx != '0);
                    n_bidx = r_bidx + IDX_W'(1);
                end else begin
                    res.status    = dmxft_pkg::ST_NO_BYTE;
                    res.frame_end = 1'b1;
                    n_phase       = dmxft_pkg::PH_IDLE;
                end
            end
            default: begin
                res.status = dmxft_pkg::ST_OK;
            end
        endcase
        res.line_low = (n_phase == dmxft_pkg::PH_BREAK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dmxft_pkg::PH_IDLE;
            r_timer <= '0;
            r_bidx  <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bidx  <= n_bidx;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == AW'(MAX_SLOTS - 1)) begin
                r_clr <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign mem_we    = r_clr || (acc && wr_ok);
    assign mem_waddr = r_clr ? r_clr_addr : i_in_data.slot_index[AW-1:0];
    assign mem_wdata = r_clr ? '0 : i_in_data.slot_value;

    dmxft_slot_ram #(
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (acc && rd_mem),
        .i_raddr (AW'(r_bidx - IDX_W'(1))),
        .o_rdata (mem_rdata)
    );

    // result stage, memory data joins here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res <= res;
            r_s1_mem <= rd_mem;
        end
    end

    always_comb begin
        s1_out = r_s1_res;
        s1_out.tx_byte = r_s1_mem ? mem_rdata : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_s1_vld && s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv) begin
            r_out <= s1_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ sim/tb_dmx512_frame_transmitter_core.sv @@
// self-checking testbench for the dmx512 frame transmitter core
module tb_dmx512_frame_transmitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS      = dmxft_pkg::MAX_SLOTS_DEF;
    localparam int FRAME_BYTES    = MAX_SLOTS + 1;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int FILL_ITEMS     = 240;
    localparam int EXTREME_ITEMS  = 60;
    localparam int FRAME_ITEM_CAP = 4096;
    localparam int DRAIN_CYCLES   = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    dmxft_pkg::t_in        i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    dmxft_pkg::t_out       o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    dmx512_frame_transmitter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // sequencer state as the testbench sees it
    logic [dmxft_pkg::BYTE_W-1:0] slot_mem [0:FRAME_BYTES-1];
    dmxft_pkg::t_phase            frame_phase;
    logic [dmxft_pkg::TICK_W-1:0] phase_left;
    logic [9:0]                   byte_ptr;
    logic [dmxft_pkg::TICK_W-1:0] break_len;
    logic [dmxft_pkg::TICK_W-1:0] mab_len;

    dmxft_pkg::t_out due_results[$];
    int   err_count   = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    bit   idle_off    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic dmxft_pkg::t_out advance_sequencer(dmxft_pkg::t_in it);
        dmxft_pkg::t_out r;
        r = '0;
        r.status = dmxft_pkg::ST_OK;
        case (it.command)
            dmxft_pkg::CMD_WRITE: begin
                if (frame_phase != dmxft_pkg::PH_IDLE)
                    r.status = dmxft_pkg::ST_BUSY;
                else if (it.slot_index >= MAX_SLOTS)
                    r.status = dmxft_pkg::ST_TOO_MANY;
                else
                    slot_mem[it.slot_index + 1] = it.slot_value;
            end
            dmxft_pkg::CMD_START: begin
                if (frame_phase != dmxft_pkg::PH_IDLE) begin
                    r.status = dmxft_pkg::ST_BUSY;
                end else if (it.slot_count > MAX_SLOTS) begin
                    r.status = dmxft_pkg::ST_TOO_MANY;
                end else begin
                    frame_phase = dmxft_pkg::PH_BREAK;
                    phase_left  = break_len;
                end
            end
            dmxft_pkg::CMD_TICK: begin
                if (frame_phase == dmxft_pkg::PH_BREAK) begin
                    if (phase_left <= 1) begin
                        frame_phase = dmxft_pkg::PH_MARK;
                        phase_left  = mab_len;
                    end else begin
                        phase_left = phase_left - 1'b1;
                    end
                end else if (frame_phase == dmxft_pkg::PH_MARK) begin
                    if (phase_left <= 1) begin
                        frame_phase  = dmxft_pkg::PH_DATA;
                        phase_left   = '0;
                        byte_ptr     = '0;
                        r.data_ready = 1'b1;
                    end else begin
                        phase_left = phase_left - 1'b1;
                    end
                end
            end
            default: begin
                if (frame_phase != dmxft_pkg::PH_DATA) begin
                    r.status = dmxft_pkg::ST_NO_BYTE;
                end else if (byte_ptr < FRAME_BYTES) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = slot_mem[byte_ptr];
                    byte_ptr   = byte_ptr + 1'b1;
                end else begin
                    r.status    = dmxft_pkg::ST_NO_BYTE;
                    r.frame_end = 1'b1;
                    frame_phase = dmxft_pkg::PH_IDLE;
                end
            end
        endcase
        r.line_low = (frame_phase == dmxft_pkg::PH_BREAK);
        return r;
    endfunction

    function automatic dmxft_pkg::t_in mk_item(dmxft_pkg::t_cmd c, int idx, int val, int cnt);
        dmxft_pkg::t_in it;
        it.command    = c;
        it.slot_index = 9'(idx);
        it.slot_value = 8'(val);
        it.slot_count = 10'(cnt);
        return it;
    endfunction

    function automatic dmxft_pkg::t_in rand_item(dmxft_pkg::t_cmd c);
        return mk_item(c, $urandom_range(0, 511), $urandom_range(0, 255),
                       $urandom_range(0, 1023));
    endfunction

    task automatic send_cmd(dmxft_pkg::t_in it);
        int gap;
        bit taken;
        gap = idle_off ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        due_results.push_back(advance_sequencer(it));
        items_sent++;
    endtask

    task automatic write_reg(dmxft_pkg::t_reg_idx idx, logic [dmxft_pkg::TICK_W-1:0] val);
        bit rdy;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = (pready === 1'b1);
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == dmxft_pkg::REG_BREAK_TICKS)
            break_len = val;
        else
            mab_len = val;
    endtask

    task automatic reconfigure(logic [dmxft_pkg::TICK_W-1:0] brk,
                               logic [dmxft_pkg::TICK_W-1:0] mab);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(dmxft_pkg::REG_BREAK_TICKS, brk);
        write_reg(dmxft_pkg::REG_MAB_TICKS, mab);
    endtask

    // start if idle, tick through break and mark, fetch bytes until frame end or cap
    task automatic play_frame(int noise_pct, int max_items);
        dmxft_pkg::t_in it;
        int n;
        n = 0;
        if (frame_phase == dmxft_pkg::PH_IDLE) begin
            it = rand_item(dmxft_pkg::CMD_START);
            it.slot_count = 10'($urandom_range(0, MAX_SLOTS));
            send_cmd(it);
        end
        while (frame_phase != dmxft_pkg::PH_IDLE && n < max_items) begin
            if ($urandom_range(0, 99) < noise_pct)
                it = rand_item(dmxft_pkg::t_cmd'($urandom_range(0, 3)));
            else
                it = rand_item(frame_phase == dmxft_pkg::PH_DATA ? dmxft_pkg::CMD_NEXT
                                                                 : dmxft_pkg::CMD_TICK);
            send_cmd(it);
            n++;
            if ($urandom_range(0, 99) == 0)
                idle_off = !idle_off;
        end
    endtask

    task automatic test_idle_requests();
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 0, 8'hFF, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 511, 8'hFF, 1023));
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 1, 8'h00, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 510, 8'h80, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 256, 8'h01, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_TICK, 0, 0, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_NEXT, 0, 0, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_START, 0, 0, MAX_SLOTS + 1));
        send_cmd(mk_item(dmxft_pkg::CMD_START, 511, 255, 1023));
    endtask

    // random traffic while idle, starts always carry too many slots
    task automatic test_slot_fill();
        dmxft_pkg::t_in it;
        repeat (FILL_ITEMS) begin
            it = rand_item($urandom_range(0, 4) != 0 ? dmxft_pkg::CMD_WRITE
                                                     : dmxft_pkg::t_cmd'($urandom_range(0, 3)));
            if (it.command == dmxft_pkg::CMD_START)
                it.slot_count = 10'($urandom_range(MAX_SLOTS + 1, 1023));
            send_cmd(it);
            if ($urandom_range(0, 19) == 0)
                idle_off = !idle_off;
        end
        idle_off = 1'b0;
    endtask

    task automatic test_reset_timing_frame();
        send_cmd(mk_item(dmxft_pkg::CMD_START, 0, 0, MAX_SLOTS));
        send_cmd(mk_item(dmxft_pkg::CMD_START, 0, 0, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_WRITE, 5, 8'h55, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_NEXT, 0, 0, 0));
        send_cmd(mk_item(dmxft_pkg::CMD_TICK, 0, 0, 0));
        play_frame(0, FRAME_ITEM_CAP);
    endtask

    task automatic test_tick_extremes();
        // zero length behaves as a single tick
        reconfigure(10'd0, 10'd0);
        send_cmd(mk_item(dmxft_pkg::CMD_START, 0, 0, 0));
        play_frame(5, EXTREME_ITEMS);
        idle_off = 1'b0;
    endtask

    task automatic cmp_field(string fld, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            err_count++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, fld, want, seen);
        end
    endtask

    initial begin : result_monitor
        dmxft_pkg::t_out seen;
        dmxft_pkg::t_out want;
        int   hold;
        bit   taken;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = idle_off ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                taken = (o_out_valid === 1'b1);
                seen  = o_out_data;
                @(posedge i_clk);
            end while (!taken);
            if (due_results.size() == 0) begin
                err_count++;
                $display("%0t unexpected transaction: expected none actual %h", $time, seen);
            end else begin
                want = due_results.pop_front();
                cmp_field("status", 32'(want.status), 32'(seen.status));
                cmp_field("line_low", 32'(want.line_low), 32'(seen.line_low));
                cmp_field("data_ready", 32'(want.data_ready), 32'(seen.data_ready));
                cmp_field("tx_valid", 32'(want.tx_valid), 32'(seen.tx_valid));
                cmp_field("tx_byte", 32'(want.tx_byte), 32'(seen.tx_byte));
                cmp_field("frame_end", 32'(want.frame_end), 32'(seen.frame_end));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        foreach (slot_mem[i]) slot_mem[i] = '0;
        frame_phase = dmxft_pkg::PH_IDLE;
        phase_left  = '0;
        byte_ptr    = '0;
        break_len   = dmxft_pkg::BREAK_TICKS_RST;
        mab_len     = dmxft_pkg::MAB_TICKS_RST;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_requests();
        test_slot_fill();
        test_reset_timing_frame();
        test_tick_extremes();

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
